// ===== rtl/core/lps_pkg.sv =====
`timescale 1ns / 1ps

package lps_pkg;

  // Default build values for the top-level parameters.
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed field widths.
  localparam int LAP_W       = 24;
  localparam int PRIOR_W     = 24;
  localparam int GRID_W_BITS = 11;
  localparam int GRID_H_BITS = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_MODE    = 2'd2;

  // Reset values of the configuration registers.
  localparam int GRID_W_RESET = 1024;
  localparam int GRID_H_RESET = 1024;

  // Item kinds.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  // Saturation limits of the result.
  localparam logic signed [LAP_W-1:0] LAP_MAX = 24'sh7FFFFF;
  localparam logic signed [LAP_W-1:0] LAP_MIN = 24'sh800000;

  // Per-beat control decided when an item is taken in.
  typedef struct packed {
    logic emit;
    logic interior;
    logic col0;
    logic sample_item;
    logic frame_end;
  } lps_issue_t;

endpackage

// ===== rtl/core/lps_in_if.sv =====
`timescale 1ns / 1ps

interface lps_in_if #(
  parameter int SAMPLE_BITS = lps_pkg::SAMPLE_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic signed [SAMPLE_BITS-1:0]     sample;
  logic signed [lps_pkg::PRIOR_W-1:0] prior_value;

  modport source (output valid, output kind, output sample, output prior_value, input ready);
  modport sink   (input valid, input kind, input sample, input prior_value, output ready);
endinterface

// ===== rtl/core/lps_out_if.sv =====
`timescale 1ns / 1ps

interface lps_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [lps_pkg::LAP_W-1:0] laplacian_value;
  logic                             frame_end;
  logic                             saturated;

  modport source (output valid, output laplacian_value, output frame_end, output saturated,
                  input ready);
  modport sink   (input valid, input laplacian_value, input frame_end, input saturated,
                  output ready);
endinterface

// ===== rtl/core/laplacian_5point_stencil_core.sv =====
`timescale 1ns / 1ps
// Five-point Laplacian stencil over a raster stream of grid samples.
// Throughput: one beat per cycle unless the result side stalls, set by the line-buffer
// read and write. A result passes through stage one and the output register after the beat
// that releases it (the sample directly below its position, or a flush beat for the last
// row). Reset: position counters clear and registers return to their reset values; the line
// buffers are not cleared, as every read value in use was written earlier in the same frame.

module laplacian_5point_stencil_core #(
  parameter int MAX_WIDTH   = lps_pkg::MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = lps_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lps_pkg::CFG_W-1:0]     cfg_data,
  lps_in_if.sink                        in_ch,
  lps_out_if.source                     out_ch
);
  import lps_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic                          accept;
  logic                          in_ready;
  lps_issue_t                    issue;
  logic                          acc_mode;
  logic [CW:0]                   s_raddr_a;
  logic [CW:0]                   s_raddr_b;
  logic                          s_we;
  logic [CW:0]                   s_waddr;
  logic [CW-1:0]                 p_raddr;
  logic                          p_we;
  logic [CW-1:0]                 p_waddr;
  logic signed [SAMPLE_BITS-1:0] s_q_a;
  logic signed [SAMPLE_BITS-1:0] s_q_b;
  logic signed [PRIOR_W-1:0]     p_q;

  // Input beat handshake.
  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;

  lps_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .kind      (in_ch.kind),
    .issue     (issue),
    .acc_mode  (acc_mode),
    .s_raddr_a (s_raddr_a),
    .s_raddr_b (s_raddr_b),
    .s_we      (s_we),
    .s_waddr   (s_waddr),
    .p_raddr   (p_raddr),
    .p_we      (p_we),
    .p_waddr   (p_waddr)
  );

  lps_line_mem #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mem (
    .clk       (clk),
    .rd_en     (accept),
    .s_raddr_a (s_raddr_a),
    .s_raddr_b (s_raddr_b),
    .s_we      (s_we),
    .s_waddr   (s_waddr),
    .s_wdata   (in_ch.sample),
    .s_q_a     (s_q_a),
    .s_q_b     (s_q_b),
    .p_raddr   (p_raddr),
    .p_we      (p_we),
    .p_waddr   (p_waddr),
    .p_wdata   (in_ch.prior_value),
    .p_q       (p_q)
  );

  lps_calc #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_calc (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_ready (in_ready),
    .issue    (issue),
    .acc_mode (acc_mode),
    .sample   (in_ch.sample),
    .s_q_a    (s_q_a),
    .s_q_b    (s_q_b),
    .p_q      (p_q),
    .out_ch   (out_ch)
  );

endmodule

// ===== rtl/core/lps_line_mem.sv =====
`timescale 1ns / 1ps

module lps_line_mem #(
  parameter int MAX_WIDTH   = lps_pkg::MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = lps_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rd_en,
  input  logic [$clog2(MAX_WIDTH):0]           s_raddr_a,
  input  logic [$clog2(MAX_WIDTH):0]           s_raddr_b,
  input  logic                                 s_we,
  input  logic [$clog2(MAX_WIDTH):0]           s_waddr,
  input  logic signed [SAMPLE_BITS-1:0]        s_wdata,
  output logic signed [SAMPLE_BITS-1:0]        s_q_a,
  output logic signed [SAMPLE_BITS-1:0]        s_q_b,
  input  logic [$clog2(MAX_WIDTH)-1:0]         p_raddr,
  input  logic                                 p_we,
  input  logic [$clog2(MAX_WIDTH)-1:0]         p_waddr,
  input  logic signed [lps_pkg::PRIOR_W-1:0]   p_wdata,
  output logic signed [lps_pkg::PRIOR_W-1:0]   p_q
);
  import lps_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  // Two row banks of samples, selected by the top address bit.
  logic signed [SAMPLE_BITS-1:0] sample_mem [2 << CW];
  // One row of prior values.
  logic signed [PRIOR_W-1:0]     prior_mem  [1 << CW];

  // Sample line buffer: two read ports, one write port, read-before-write.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      s_q_a <= sample_mem[s_raddr_a];
      s_q_b <= sample_mem[s_raddr_b];
    end
    if (s_we) begin
      sample_mem[s_waddr] <= s_wdata;
    end
  end

  // Prior line buffer: one read port, one write port, read-before-write.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      p_q <= prior_mem[p_raddr];
    end
    if (p_we) begin
      prior_mem[p_waddr] <= p_wdata;
    end
  end

endmodule

// ===== rtl/core/lps_ctrl.sv =====
`timescale 1ns / 1ps

module lps_ctrl #(
  parameter int MAX_WIDTH = lps_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lps_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              accept,
  input  logic                              kind,
  output lps_pkg::lps_issue_t               issue,
  output logic                              acc_mode,
  output logic [$clog2(MAX_WIDTH):0]        s_raddr_a,
  output logic [$clog2(MAX_WIDTH):0]        s_raddr_b,
  output logic                              s_we,
  output logic [$clog2(MAX_WIDTH):0]        s_waddr,
  output logic [$clog2(MAX_WIDTH)-1:0]      p_raddr,
  output logic                              p_we,
  output logic [$clog2(MAX_WIDTH)-1:0]      p_waddr
);
  import lps_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int W_RESET = (GRID_W_RESET > MAX_WIDTH) ? MAX_WIDTH : GRID_W_RESET;

  // Configuration, held as the last column and last row index.
  logic [CW-1:0]          w_last_r, w_last_nxt;
  logic [GRID_H_BITS-1:0] h_last_r, h_last_nxt;
  logic                   acc_mode_r, acc_mode_nxt;

  // Position counters.
  logic [CW-1:0]          in_col_r, in_col_nxt;
  logic [GRID_H_BITS-1:0] in_row_r, in_row_nxt;
  logic                   in_done_r, in_done_nxt;
  logic [CW-1:0]          out_col_r, out_col_nxt;
  logic [GRID_H_BITS-1:0] out_row_r, out_row_nxt;

  logic [GRID_W_BITS-1:0] gw;
  logic [GRID_H_BITS-1:0] gh;
  logic                   sample_ok;
  logic                   flush_ok;
  logic                   emit;
  logic                   in_col_last;
  logic                   out_col_last;
  logic                   out_last;
  logic                   cur_bank;

  assign gw = cfg_data[GRID_W_BITS-1:0];
  assign gh = cfg_data[GRID_H_BITS-1:0];

  // Classify the beat on offer.
  assign sample_ok    = (kind == KIND_SAMPLE) && !in_done_r;
  assign flush_ok     = (kind == KIND_FLUSH) && in_done_r;
  assign emit         = (sample_ok && (in_row_r != '0)) || flush_ok;
  assign in_col_last  = (in_col_r == w_last_r);
  assign out_col_last = (out_col_r == w_last_r);
  assign out_last     = out_col_last && (out_row_r == h_last_r);
  assign cur_bank     = in_row_r[0];

  assign issue.emit        = emit;
  assign issue.interior    = (in_row_r[GRID_H_BITS-1:1] != '0) && (in_col_r != '0) &&
                             !in_col_last;
  assign issue.col0        = (in_col_r == '0);
  assign issue.sample_item = sample_ok;
  assign issue.frame_end   = out_last;
  assign acc_mode          = acc_mode_r;

  // Port A reads the row two above, or the start of the row above in column zero.
  // Port B runs one column ahead along the row above.
  assign s_raddr_a = (in_col_r == '0) ? {~cur_bank, {CW{1'b0}}} : {cur_bank, in_col_r};
  assign s_raddr_b = {~cur_bank, in_col_r + CW'(1)};
  assign s_we      = accept && sample_ok;
  assign s_waddr   = {cur_bank, in_col_r};
  assign p_raddr   = (kind == KIND_FLUSH) ? out_col_r : in_col_r;
  assign p_we      = accept && sample_ok;
  assign p_waddr   = in_col_r;

  // Next state of configuration and counters.
  always_comb begin
    logic restart;
    restart      = 1'b0;
    w_last_nxt   = w_last_r;
    h_last_nxt   = h_last_r;
    acc_mode_nxt = acc_mode_r;
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    in_done_nxt  = in_done_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_GRID_WIDTH: begin
          if (gw == '0) begin
            w_last_nxt = '0;
          end else if (int'(gw) > MAX_WIDTH) begin
            w_last_nxt = CW'(MAX_WIDTH - 1);
          end else begin
            w_last_nxt = CW'(gw - GRID_W_BITS'(1));
          end
          restart = 1'b1;
        end
        REG_GRID_HEIGHT: begin
          h_last_nxt = (gh == '0) ? '0 : gh - GRID_H_BITS'(1);
          restart    = 1'b1;
        end
        REG_ACC_MODE: begin
          acc_mode_nxt = cfg_data[0];
          restart      = 1'b1;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (sample_ok) begin
        if (in_col_last) begin
          in_col_nxt = '0;
          if (in_row_r == h_last_r) begin
            in_done_nxt = 1'b1;
          end else begin
            in_row_nxt = in_row_r + GRID_H_BITS'(1);
          end
        end else begin
          in_col_nxt = in_col_r + CW'(1);
        end
      end
      if (emit) begin
        if (out_col_last) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + GRID_H_BITS'(1);
        end else begin
          out_col_nxt = out_col_r + CW'(1);
        end
      end
      if (flush_ok && out_last) begin
        restart = 1'b1;
      end
    end
    if (restart) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      in_done_nxt = 1'b0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r   <= CW'(W_RESET - 1);
      h_last_r   <= GRID_H_BITS'(GRID_H_RESET - 1);
      acc_mode_r <= 1'b0;
      in_col_r   <= '0;
      in_row_r   <= '0;
      in_done_r  <= 1'b0;
      out_col_r  <= '0;
      out_row_r  <= '0;
    end else begin
      w_last_r   <= w_last_nxt;
      h_last_r   <= h_last_nxt;
      acc_mode_r <= acc_mode_nxt;
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      in_done_r  <= in_done_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
    end
  end

endmodule

// ===== rtl/core/lps_calc.sv =====
`timescale 1ns / 1ps

module lps_calc #(
  parameter int SAMPLE_BITS = lps_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               accept,
  output logic                               in_ready,
  input  lps_pkg::lps_issue_t                issue,
  input  logic                               acc_mode,
  input  logic signed [SAMPLE_BITS-1:0]      sample,
  input  logic signed [SAMPLE_BITS-1:0]      s_q_a,
  input  logic signed [SAMPLE_BITS-1:0]      s_q_b,
  input  logic signed [lps_pkg::PRIOR_W-1:0] p_q,
  lps_out_if.source                          out_ch
);
  import lps_pkg::*;

  localparam int ACC_W = ((SAMPLE_BITS + 4 > LAP_W) ? SAMPLE_BITS + 4 : LAP_W) + 1;

  // Stage one: the beat whose line-buffer reads are now on the memory outputs.
  logic                          s1_valid_r, s1_valid_nxt;
  lps_issue_t                    s1_issue_r;
  logic signed [SAMPLE_BITS-1:0] s1_down_r;

  // Three-tap window along the row above.
  logic signed [SAMPLE_BITS-1:0] win_left_r;
  logic signed [SAMPLE_BITS-1:0] win_mid_r;

  // Output register.
  logic                          out_valid_r, out_valid_nxt;
  logic signed [LAP_W-1:0]       out_val_r;
  logic                          out_end_r;
  logic                          out_sat_r;

  logic                          s1_move;
  logic signed [ACC_W-1:0]       stencil;
  logic signed [ACC_W-1:0]       total;
  logic signed [LAP_W-1:0]       clamped;
  logic                          sat;

  // Stage one moves on when the output register is free or being emptied.
  assign s1_move  = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready = !s1_valid_r || s1_move;

  // Stencil sum, prior and clamp.
  always_comb begin
    stencil = ACC_W'(s_q_a) + ACC_W'(s1_down_r) + ACC_W'(win_left_r) + ACC_W'(s_q_b)
              - (ACC_W'(win_mid_r) <<< 2);
    total   = (s1_issue_r.interior ? stencil : '0) + (acc_mode ? ACC_W'(p_q) : '0);
    sat     = 1'b0;
    clamped = total[LAP_W-1:0];
    if (total > ACC_W'(LAP_MAX)) begin
      clamped = LAP_MAX;
      sat     = 1'b1;
    end else if (total < ACC_W'(LAP_MIN)) begin
      clamped = LAP_MIN;
      sat     = 1'b1;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = s1_issue_r.emit;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_issue_r <= issue;
      s1_down_r  <= sample;
    end
    if (s1_move && s1_issue_r.sample_item) begin
      if (s1_issue_r.col0) begin
        win_left_r <= s_q_a;
      end else begin
        win_left_r <= win_mid_r;
      end
      win_mid_r <= s_q_b;
    end
    if (s1_move) begin
      out_val_r <= clamped;
      out_end_r <= s1_issue_r.frame_end;
      out_sat_r <= sat;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.laplacian_value = out_val_r;
  assign out_ch.frame_end       = out_end_r;
  assign out_ch.saturated       = out_sat_r;

endmodule

// ===== verif/lps_result_checker.sv =====
`timescale 1ns / 1ps

module lps_result_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lps_pkg::CFG_W-1:0]     cfg_data,
  lps_in_if                             in_mon,
  lps_out_if                            out_mon,
  output int                            fail_count,
  output int                            pending,
  output int                            checked,
  output int                            clamped
);

  localparam int LINE_W = lps_pkg::MAX_WIDTH_DEF;
  localparam int SAMP_W = lps_pkg::SAMPLE_BITS_DEF;
  localparam int REPORT_CAP = 40;

  typedef struct packed {
    logic signed [lps_pkg::LAP_W-1:0] value;
    logic                             frame_end;
    logic                             saturated;
  } lap_result_t;

  // Shadow of the line buffers, the position counters and the registers.
  logic [SAMP_W-1:0]           sample_rows [2*LINE_W];
  logic [lps_pkg::PRIOR_W-1:0] prior_row [LINE_W];
  int unsigned                 col_in, row_in, col_out, row_out;
  logic [lps_pkg::GRID_W_BITS-1:0] width_reg;
  logic [lps_pkg::GRID_H_BITS-1:0] height_reg;
  logic                            acc_reg;

  // Results still owed by the block, oldest first.
  lap_result_t expected_q[$];

  // Appends one result that the block now owes.
  function automatic void owe_result(input lap_result_t res);
    expected_q.insert(expected_q.size(), res);
  endfunction

  // Width and height as the block uses them, out-of-range values folded in.
  function automatic int unsigned grid_cols();
    if (width_reg == 0) return 1;
    if (width_reg > LINE_W) return LINE_W;
    return width_reg;
  endfunction

  function automatic int unsigned grid_rows();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic void restart_frame();
    col_in  = 0;
    row_in  = 0;
    col_out = 0;
    row_out = 0;
  endfunction

  // Moves the output position on and tells whether it was the last one.
  function automatic bit step_out(input int unsigned w, input int unsigned h);
    bit last;
    last = (row_out + 1 >= h) && (col_out + 1 >= w);
    if (col_out + 1 >= w) begin
      col_out = 0;
      row_out++;
    end else begin
      col_out++;
    end
    return last;
  endfunction

  function automatic lap_result_t clamp_result(input int sum, input bit fend);
    lap_result_t res;
    res.frame_end = fend;
    res.saturated = 1'b0;
    if (sum > int'(lps_pkg::LAP_MAX)) begin
      res.value     = lps_pkg::LAP_MAX;
      res.saturated = 1'b1;
    end else if (sum < int'(lps_pkg::LAP_MIN)) begin
      res.value     = lps_pkg::LAP_MIN;
      res.saturated = 1'b1;
    end else begin
      res.value = 24'(sum);
    end
    return res;
  endfunction

  // A register write; only the three real registers restart the frame.
  task automatic apply_write(input logic [lps_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lps_pkg::CFG_W-1:0] data);
    case (idx)
      lps_pkg::REG_GRID_WIDTH: begin
        width_reg = data[lps_pkg::GRID_W_BITS-1:0];
        restart_frame();
      end
      lps_pkg::REG_GRID_HEIGHT: begin
        height_reg = data[lps_pkg::GRID_H_BITS-1:0];
        restart_frame();
      end
      lps_pkg::REG_ACC_MODE: begin
        acc_reg = data[0];
        restart_frame();
      end
      default: begin
      end
    endcase
  endtask

  // Works out what one accepted input beat releases.
  task automatic take_beat(input logic kind, input logic [SAMP_W-1:0] sbits,
                           input logic [lps_pkg::PRIOR_W-1:0] pbits);
    int unsigned w, h, r, c, cur, prv;
    int sum;
    bit inner, last;
    w = grid_cols();
    h = grid_rows();
    if (kind == lps_pkg::KIND_SAMPLE) begin
      r = row_in;
      c = col_in;
      // The whole grid is in but not yet flushed: the sample is dropped.
      if (r >= h || c >= LINE_W) return;
      cur = (r % 2) * LINE_W;
      prv = ((r + 1) % 2) * LINE_W;
      // The sample below a position releases the result of that position.
      if (r >= 1) begin
        sum   = 0;
        inner = (r >= 2) && (c >= 1) && (c + 1 < w);
        if (inner) begin
          sum = int'($signed(sample_rows[cur + c])) + int'($signed(sbits))
              + int'($signed(sample_rows[prv + c - 1]))
              + int'($signed(sample_rows[prv + c + 1]))
              - 4 * int'($signed(sample_rows[prv + c]));
        end
        if (acc_reg) sum += int'($signed(prior_row[c]));
        last = step_out(w, h);
        owe_result(clamp_result(sum, last));
      end
      sample_rows[cur + c] = sbits;
      prior_row[c]         = pbits;
      if (c + 1 >= w) begin
        col_in = 0;
        row_in++;
      end else begin
        col_in++;
      end
    end else begin
      // A flush before the grid is complete does nothing.
      if (row_in < h || col_out >= LINE_W) return;
      sum  = acc_reg ? int'($signed(prior_row[col_out])) : 0;
      last = step_out(w, h);
      owe_result(clamp_result(sum, last));
      if (last) restart_frame();
    end
  endtask

  task automatic check_result();
    lap_result_t want;
    if (expected_q.size() == 0) begin
      if (fail_count < REPORT_CAP)
        $display("%0t: result beat with nothing expected: %s%0d %s%0b %s%0b",
                 $time, "value=", out_mon.laplacian_value,
                 "frame_end=", out_mon.frame_end, "saturated=", out_mon.saturated);
      fail_count++;
      return;
    end
    want = expected_q.pop_front();
    if (out_mon.laplacian_value !== want.value || out_mon.frame_end !== want.frame_end ||
        out_mon.saturated !== want.saturated) begin
      if (fail_count < REPORT_CAP)
        $display("%0t: result mismatch: expected value=%0d frame_end=%0b %s%0b, %s%0d %s%0b %s%0b",
                 $time, $signed(want.value), want.frame_end, "saturated=", want.saturated,
                 "actual value=", out_mon.laplacian_value,
                 "frame_end=", out_mon.frame_end, "saturated=", out_mon.saturated);
      fail_count++;
    end
    checked++;
    if (want.saturated) clamped++;
  endtask

  // Everything is sampled at the rising edge, inputs before results.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2 * LINE_W; i++) sample_rows[i] = '0;
      for (int i = 0; i < LINE_W; i++) prior_row[i] = '0;
      restart_frame();
      width_reg  = lps_pkg::GRID_W_RESET;
      height_reg = lps_pkg::GRID_H_RESET;
      acc_reg    = 1'b0;
      expected_q.delete();
      fail_count = 0;
      checked    = 0;
      clamped    = 0;
    end else begin
      if (cfg_we) apply_write(cfg_index, cfg_data);
      if (in_mon.valid && in_mon.ready)
        take_beat(in_mon.kind, in_mon.sample, in_mon.prior_value);
      if (out_mon.valid && out_mon.ready) check_result();
    end
    pending = expected_q.size();
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  import lps_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 70;
  localparam int CALM_ITEMS   = 25;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int fail_count, pending, checked, clamped;
  int cycle_count;
  int work_items, settings_used, target;
  int cur_w, cur_h, gw, gh;
  int stall_left = 0;
  bit idle_on, calm;

  lps_in_if  in_ch ();
  lps_out_if out_ch ();

  laplacian_5point_stencil_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  lps_result_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .clamped    (clamped)
  );

  // 2 ns clock.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Run limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

  // Result side: the receiver stalls in random bursts.
  always @(negedge clk) begin
    if (stall_left == 0 && idle_on && !calm && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 9);
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Sample values weighted towards the extremes.
  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($signed($urandom_range(0, 30)) - 15);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] rand_prior();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(0, 255));
      default: return 24'($urandom);
    endcase
  endfunction

  // One input beat, with an optional gap in front; returns at a falling edge.
  task automatic send_beat(input logic kind, input logic [15:0] smp,
                           input logic [23:0] pri);
    if (idle_on && !calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= kind;
    in_ch.sample      <= smp;
    in_ch.prior_value <= pri;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Waits until every owed result is out and the pipeline has drained.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  // Writes all three registers; unused upper bits are sometimes set.
  task automatic program_grid(input int w_val, input int h_val, input bit acc);
    logic [CFG_W-GRID_W_BITS-1:0] hi_bits;
    logic [CFG_W-2:0]             acc_pad;
    logic [GRID_W_BITS-1:0]       w_bits;
    settle();
    hi_bits = ($urandom_range(0, 3) == 0) ? (CFG_W-GRID_W_BITS)'($urandom) : '0;
    acc_pad = ($urandom_range(0, 3) == 0) ? (CFG_W-1)'($urandom) : '0;
    w_bits  = GRID_W_BITS'(w_val);
    write_reg(REG_GRID_WIDTH, {hi_bits, w_bits});
    write_reg(REG_GRID_HEIGHT, CFG_W'(h_val));
    write_reg(REG_ACC_MODE, {acc_pad, acc});
    cfg_we <= 1'b0;
    cur_w = (w_bits == 0) ? 1 : ((w_bits > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(w_bits));
    cur_h = (h_val[15:0] == 0) ? 1 : int'(h_val[15:0]);
    settings_used++;
  endtask

  // Sends count samples of a frame, then its flush row if asked; stray flushes
  // before the grid is complete and stray samples before the flush are dropped.
  task automatic run_frame(input int w, input int count, input bit with_flush);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 30) == 0) send_beat(KIND_FLUSH, rand_sample(), rand_prior());
      send_beat(KIND_SAMPLE, rand_sample(), rand_prior());
      work_items++;
    end
    if (with_flush) begin
      for (int f = 0; f < w; f++) begin
        if ($urandom_range(0, 15) == 0) send_beat(KIND_SAMPLE, rand_sample(), rand_prior());
        send_beat(KIND_FLUSH, rand_sample(), rand_prior());
        work_items++;
      end
    end
  endtask

  // A 3 by 3 grid whose single interior point sees the largest stencil.
  task automatic directed_frame(input logic [15:0] ring, input logic [15:0] centre,
                                input logic [23:0] pri, input bit noisy);
    if (noisy) send_beat(KIND_FLUSH, centre, pri);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        send_beat(KIND_SAMPLE, (r == 1 && c == 1) ? centre : ring, pri);
        work_items++;
      end
    end
    if (noisy) send_beat(KIND_SAMPLE, ring, pri);
    for (int f = 0; f < 3; f++) begin
      send_beat(KIND_FLUSH, ring, pri);
      work_items++;
    end
  endtask

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_SAMPLE;
    in_ch.sample      = '0;
    in_ch.prior_value = '0;
    cfg_we            = 1'b0;
    cfg_index         = REG_GRID_WIDTH;
    cfg_data          = '0;
    rst_n             = 1'b0;
    idle_on           = 1'b0;
    calm              = 1'b0;
    work_items        = 0;
    settings_used     = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Saturation at both ends, with an early flush and a late sample.
    program_grid(3, 3, 1'b1);
    directed_frame(16'h7FFF, 16'h8000, 24'h7FFFFF, 1'b1);
    directed_frame(16'h8000, 16'h7FFF, 24'h800000, 1'b0);

    // A write to the spare index must not restart the frame.
    program_grid(2, 2, 1'b1);
    run_frame(2, 2, 1'b0);
    settle();
    write_reg(REG_SPARE, CFG_W'($urandom));
    cfg_we <= 1'b0;
    run_frame(2, 2, 1'b1);

    // Zero width and height, the tallest grid cut short, and an oversized width
    // cut short just after its first row.
    idle_on = 1'b1;
    program_grid(0, 0, 1'b1);
    run_frame(cur_w, cur_w * cur_h, 1'b1);
    run_frame(cur_w, cur_w * cur_h, 1'b1);
    program_grid(5, 65535, 1'b1);
    run_frame(cur_w, 17, 1'b0);
    program_grid(1500, 2, 1'b1);
    run_frame(cur_w, cur_w + 3, 1'b0);

    // Random grids, mostly complete frames, some abandoned part way.
    target = work_items + RANDOM_ITEMS;
    while (work_items < target) begin
      if (work_items >= target - CALM_ITEMS) calm = 1'b1;
      idle_on = !calm && ($urandom_range(0, 3) != 0);
      gw = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
      gh = (gw <= 6 && $urandom_range(0, 4) == 0) ? $urandom_range(7, 14)
                                                  : $urandom_range(1, 6);
      program_grid(gw, gh, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 5) == 0) begin
        run_frame(cur_w, $urandom_range(0, cur_w * cur_h - 1), 1'b0);
      end else begin
        repeat ($urandom_range(1, 3)) run_frame(cur_w, cur_w * cur_h, 1'b1);
      end
    end

    calm = 1'b1;
    settle();
    repeat (4) @(negedge clk);
    $display("tb_top: %0d grid items over %0d register settings, %0d results checked",
             work_items, settings_used, checked);
    $display("tb_top: %0d results clamped, widths from 1 to the maximum, in %0d cycles",
             clamped, cycle_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
